// ----- rtl/wsih_pkg.sv -----
package wsih_pkg;

   localparam int TABLE_ORDER_MAX_DEF = 10;
   localparam int WORD_MAX_DEF = 29;
   localparam int MAX_OCC_DEF = 16;
   localparam int SENTENCE_LIMIT_DEF = 1024;

   localparam int ORDER_MIN = 5;
   localparam logic [3:0] ORDER_RESET = 4'd5;

   localparam logic [1:0] FUNC_PARA = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [2:0] STAT_NEW = 3'd0;
   localparam logic [2:0] STAT_ADDED = 3'd1;
   localparam logic [2:0] STAT_FULL = 3'd2;
   localparam logic [2:0] STAT_MATCH = 3'd3;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
   localparam logic [2:0] STAT_OCC_FULL = 3'd5;

   localparam logic [7:0] CH_EXCL = 8'h21;
   localparam logic [7:0] CH_DOT = 8'h2e;
   localparam logic [7:0] CH_QUEST = 8'h3f;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_NL = 8'h0a;
   localparam logic [7:0] CH_LPAR = 8'h28;
   localparam logic [7:0] CH_RPAR = 8'h29;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_UP_M = 8'h4d;
   localparam logic [7:0] CH_UP_D = 8'h44;
   localparam logic [7:0] CH_LO_R = 8'h72;
   localparam logic [7:0] CH_LO_S = 8'h73;
   localparam logic [7:0] CH_UP_A = 8'h41;
   localparam logic [7:0] CH_UP_Z = 8'h5a;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef struct packed {
      logic restart;
      logic append;
      logic clear;
   } acc_ctl_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFFSET : c;
   endfunction

   function automatic logic [31:0] sdbm_step(input logic [31:0] h, input logic [7:0] c);
      return {24'd0, c} + (h << 6) + (h << 16) - h;
   endfunction

endpackage

// ----- rtl/word_sentence_index_hash_unit.sv -----
// channel   direction  fields
// req       in         func, char_code, last_byte
// rsp       out        status, slot_index, sentence, last_result
// csr       in         table_order (write only)
//
// a byte that ends no word is taken while the unit stays idle
// at a word end each probed slot passes S_META_WAIT and S_META, and each compared byte passes
// S_CMP_WAIT and S_CMP (slot metadata and word memories, one read port each); S_FILL writes a new word byte by byte
// a query match reads its results one by one from the sentence memory, each waiting for a free result port
// after reset and after a clear the metadata memory is swept, all 2^TABLE_ORDER_MAX slots
// a pending result does not block byte intake; the next result waits for it, and no byte is taken meanwhile
module word_sentence_index_hash_unit #(
   parameter int TABLE_ORDER_MAX = wsih_pkg::TABLE_ORDER_MAX_DEF,
   parameter int WORD_MAX = wsih_pkg::WORD_MAX_DEF,
   parameter int MAX_OCCURRENCES = wsih_pkg::MAX_OCC_DEF,
   parameter int SENTENCE_LIMIT = wsih_pkg::SENTENCE_LIMIT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_char_code,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [9:0] rsp_slot_index,
   output logic [9:0] rsp_sentence,
   output logic       rsp_last_result,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data
);
   import wsih_pkg::*;

   localparam int OW = TABLE_ORDER_MAX;
   localparam int NSLOTS = 1 << OW;
   localparam int KW = $clog2(WORD_MAX);
   localparam int LW = $clog2(WORD_MAX + 1);
   localparam int CW = $clog2(MAX_OCCURRENCES + 1);
   localparam int IW = (MAX_OCCURRENCES > 1) ? $clog2(MAX_OCCURRENCES) : 1;
   localparam int SW = $clog2(SENTENCE_LIMIT);
   localparam int WA = $clog2(NSLOTS * WORD_MAX);
   localparam int SA = $clog2(NSLOTS * MAX_OCCURRENCES);
   localparam int MW = 1 + LW + CW;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_META_WAIT = 4'd2;
   localparam logic [3:0] S_META = 4'd3;
   localparam logic [3:0] S_CMP_WAIT = 4'd4;
   localparam logic [3:0] S_CMP = 4'd5;
   localparam logic [3:0] S_FILL = 4'd6;
   localparam logic [3:0] S_EMIT = 4'd7;
   localparam logic [3:0] S_SENT_WAIT = 4'd8;
   localparam logic [3:0] S_SENT_EMIT = 4'd9;

   logic [MW-1:0] meta_mem [NSLOTS];
   logic [7:0]    word_mem [NSLOTS * WORD_MAX];
   logic [SW-1:0] sent_mem [NSLOTS * MAX_OCCURRENCES];
   logic [MW-1:0] meta_rd_ff;
   logic [7:0]    word_rd_ff;
   logic [SW-1:0] sent_rd_ff;

   logic [3:0]    state_ff, state_in;
   logic [3:0]    order_ff, order_in;
   logic [OW-1:0] clr_ff, clr_in;
   logic          in_word_ff, in_word_in;
   logic [SW-1:0] sentence_ff, sentence_in;
   logic          mode_ff, mode_in;
   logic [LW-1:0] key_len_ff, key_len_in;
   logic [SW-1:0] s_ff, s_in;
   logic [OW-1:0] start_ff, start_in, j_ff, j_in, jn;
   logic [KW-1:0] k_ff, k_in;
   logic [IW-1:0] i_ff, i_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [2:0]    res_stat_ff, res_stat_in;
   logic [OW-1:0] res_slot_ff, res_slot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_stat_ff, rsp_stat_in;
   logic [OW-1:0] rsp_slot_ff, rsp_slot_in;
   logic [SW-1:0] rsp_sent_ff, rsp_sent_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          meta_we, word_we, sent_we;
   logic [OW-1:0] meta_wa;
   logic [MW-1:0] meta_wd;
   logic [CW-1:0] sent_widx;

   acc_ctl_type   pctl, qctl;
   logic [7:0]    p_rd, q_rd, key_byte;
   logic [LW-1:0] p_len, q_len;
   logic [31:0]   p_hash, q_hash;
   logic          p_abbrev, q_abbrev_unused;

   logic [OW-1:0] mask;
   logic [3:0]    order_eff;
   logic          accept, out_free, term, skip, probe, adv;
   logic          m_used;
   logic [LW-1:0] m_len;
   logic [CW-1:0] m_cnt;
   logic [WA-1:0] word_addr;
   logic [SA-1:0] sent_raddr, sent_waddr;

   wsih_word_acc #(.WORD_MAX(WORD_MAX)) u_para (
      .clock(clock), .reset(reset), .ctl(pctl), .ch(req_char_code), .rd_idx(k_ff),
      .rd_data(p_rd), .len_after(p_len), .hash_after(p_hash), .abbrev(p_abbrev)
   );

   wsih_word_acc #(.WORD_MAX(WORD_MAX)) u_query (
      .clock(clock), .reset(reset), .ctl(qctl), .ch(req_char_code), .rd_idx(k_ff),
      .rd_data(q_rd), .len_after(q_len), .hash_after(q_hash), .abbrev(q_abbrev_unused)
   );

   always_comb begin
      if (int'(order_ff) < ORDER_MIN) begin
         order_eff = 4'(ORDER_MIN);
      end else if (int'(order_ff) > TABLE_ORDER_MAX) begin
         order_eff = 4'(TABLE_ORDER_MAX);
      end else begin
         order_eff = order_ff;
      end
      for (int b = 0; b < OW; b++) begin
         mask[b] = b < int'(order_eff);
      end
   end

   assign {m_used, m_len, m_cnt} = meta_rd_ff;
   assign key_byte = mode_ff ? q_rd : p_rd;
   assign word_addr = WA'(j_ff) * WA'(WORD_MAX) + WA'(k_ff);
   assign sent_raddr = SA'(j_ff) * SA'(MAX_OCCURRENCES) + SA'(i_ff);
   assign sent_waddr = SA'(j_ff) * SA'(MAX_OCCURRENCES) + SA'(sent_widx);
   assign jn = (j_ff + OW'(1)) & mask;
   assign accept = req_valid && state_ff == S_IDLE;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign term = req_char_code == CH_EXCL || req_char_code == CH_DOT ||
                 req_char_code == CH_QUEST;
   assign skip = req_char_code == CH_SPACE || req_char_code == CH_COMMA ||
                 req_char_code == CH_NL || req_char_code == CH_LPAR ||
                 req_char_code == CH_RPAR || req_char_code == CH_DQUOTE ||
                 req_char_code == CH_SQUOTE;

   always_comb begin
      state_in = state_ff;
      order_in = csr_write_enable ? csr_write_data : order_ff;
      clr_in = clr_ff;
      in_word_in = in_word_ff;
      sentence_in = sentence_ff;
      mode_in = mode_ff;
      key_len_in = key_len_ff;
      s_in = s_ff;
      start_in = start_ff;
      j_in = j_ff;
      k_in = k_ff;
      i_in = i_ff;
      cnt_in = cnt_ff;
      res_stat_in = res_stat_ff;
      res_slot_in = res_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_stat_in = rsp_stat_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_sent_in = rsp_sent_ff;
      rsp_last_in = rsp_last_ff;
      meta_we = 1'b0;
      meta_wa = j_ff;
      meta_wd = '0;
      word_we = 1'b0;
      sent_we = 1'b0;
      sent_widx = '0;
      pctl = '0;
      qctl = '0;
      probe = 1'b0;
      adv = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            meta_we = 1'b1;
            meta_wa = clr_ff;
            clr_in = clr_ff + OW'(1);
            if (clr_ff == OW'(NSLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_PARA: begin
                     if (!in_word_ff) begin
                        if (term) begin
                           adv = 1'b1;
                        end else if (!skip) begin
                           in_word_in = 1'b1;
                           pctl.restart = 1'b1;
                           pctl.append = 1'b1;
                        end
                     end else if (term) begin
                        probe = 1'b1;
                        in_word_in = 1'b0;
                        if (p_abbrev) begin
                           pctl.append = 1'b1;
                        end else begin
                           adv = 1'b1;
                        end
                     end else if (skip) begin
                        probe = 1'b1;
                        in_word_in = 1'b0;
                     end else begin
                        pctl.append = 1'b1;
                     end
                     s_in = sentence_ff;
                     if (adv && sentence_ff < SW'(SENTENCE_LIMIT - 1)) begin
                        sentence_in = sentence_ff + SW'(1);
                     end
                     if (req_last_byte) begin
                        in_word_in = 1'b0;
                        pctl.clear = 1'b1;
                        sentence_in = '0;
                     end
                     mode_in = 1'b0;
                     key_len_in = p_len;
                     start_in = p_hash[OW-1:0] & mask;
                  end
                  FUNC_QUERY: begin
                     qctl.append = 1'b1;
                     qctl.clear = req_last_byte;
                     probe = req_last_byte;
                     mode_in = 1'b1;
                     key_len_in = q_len;
                     start_in = q_hash[OW-1:0] & mask;
                  end
                  FUNC_CLEAR: begin
                     clr_in = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                  end
               endcase
               if (probe) begin
                  j_in = start_in;
                  state_in = S_META_WAIT;
               end
            end
         end
         S_META_WAIT: begin
            state_in = S_META;
         end
         S_META, S_CMP: begin
            if (state_ff == S_META && !m_used) begin
               res_slot_in = j_ff;
               if (!mode_ff) begin
                  meta_we = 1'b1;
                  meta_wd = {1'b1, key_len_ff, CW'(1)};
                  sent_we = 1'b1;
                  res_stat_in = STAT_NEW;
                  k_in = '0;
                  state_in = (key_len_ff == '0) ? S_EMIT : S_FILL;
               end else begin
                  res_stat_in = STAT_NOT_FOUND;
                  state_in = S_EMIT;
               end
            end else if ((state_ff == S_META && m_len == key_len_ff) ||
                         (state_ff == S_CMP && word_rd_ff == key_byte)) begin
               if (state_ff == S_META && key_len_ff != '0) begin
                  k_in = '0;
                  state_in = S_CMP_WAIT;
               end else if (state_ff == S_CMP && LW'(k_ff) + LW'(1) != key_len_ff) begin
                  k_in = k_ff + KW'(1);
                  state_in = S_CMP_WAIT;
               end else if (mode_ff) begin
                  cnt_in = m_cnt;
                  i_in = '0;
                  state_in = S_SENT_WAIT;
               end else begin
                  res_slot_in = j_ff;
                  state_in = S_EMIT;
                  if (m_cnt < CW'(MAX_OCCURRENCES)) begin
                     meta_we = 1'b1;
                     meta_wd = {1'b1, m_len, m_cnt + CW'(1)};
                     sent_we = 1'b1;
                     sent_widx = m_cnt;
                     res_stat_in = STAT_ADDED;
                  end else begin
                     res_stat_in = STAT_OCC_FULL;
                  end
               end
            end else if (jn == start_ff) begin
               res_slot_in = start_ff;
               res_stat_in = mode_ff ? STAT_NOT_FOUND : STAT_FULL;
               state_in = S_EMIT;
            end else begin
               j_in = jn;
               state_in = S_META_WAIT;
            end
         end
         S_CMP_WAIT: begin
            state_in = S_CMP;
         end
         S_FILL: begin
            word_we = 1'b1;
            k_in = k_ff + KW'(1);
            if (LW'(k_ff) + LW'(1) == key_len_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in = res_stat_ff;
               rsp_slot_in = res_slot_ff;
               rsp_sent_in = (res_stat_ff == STAT_NOT_FOUND) ? '0 : s_ff;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SENT_WAIT: begin
            state_in = S_SENT_EMIT;
         end
         S_SENT_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in = STAT_MATCH;
               rsp_slot_in = j_ff;
               rsp_sent_in = sent_rd_ff;
               rsp_last_in = CW'(i_ff) + CW'(1) == cnt_ff;
               if (rsp_last_in) begin
                  state_in = S_IDLE;
               end else begin
                  i_in = i_ff + IW'(1);
                  state_in = S_SENT_WAIT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         order_ff <= ORDER_RESET;
         clr_ff <= '0;
         in_word_ff <= 1'b0;
         sentence_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         order_ff <= order_in;
         clr_ff <= clr_in;
         in_word_ff <= in_word_in;
         sentence_ff <= sentence_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      key_len_ff <= key_len_in;
      s_ff <= s_in;
      start_ff <= start_in;
      j_ff <= j_in;
      k_ff <= k_in;
      i_ff <= i_in;
      cnt_ff <= cnt_in;
      res_stat_ff <= res_stat_in;
      res_slot_ff <= res_slot_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_sent_ff <= rsp_sent_in;
      rsp_last_ff <= rsp_last_in;
   end

   // slot memories, registered reads at the current probe position
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      meta_rd_ff <= meta_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_addr] <= key_byte;
      end
      word_rd_ff <= word_mem[word_addr];
   end

   always_ff @(posedge clock) begin
      if (sent_we) begin
         sent_mem[sent_waddr] <= s_ff;
      end
      sent_rd_ff <= sent_mem[sent_raddr];
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_stat_ff;
   assign rsp_slot_index = 10'(rsp_slot_ff);
   assign rsp_sentence = 10'(rsp_sent_ff);
   assign rsp_last_result = rsp_last_ff;

endmodule

// ----- rtl/wsih_word_acc.sv -----
module wsih_word_acc #(
   parameter int WORD_MAX = wsih_pkg::WORD_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  wsih_pkg::acc_ctl_type            ctl,
   input  logic [7:0]                       ch,
   input  logic [$clog2(WORD_MAX)-1:0]      rd_idx,
   output logic [7:0]                       rd_data,
   output logic [$clog2(WORD_MAX+1)-1:0]    len_after,
   output logic [31:0]                      hash_after,
   output logic                             abbrev
);
   import wsih_pkg::*;

   localparam int KW = $clog2(WORD_MAX);
   localparam int LW = $clog2(WORD_MAX + 1);

   logic [7:0]    char_ff [WORD_MAX];
   logic [7:0]    first_raw_ff;
   logic [LW-1:0] len_ff, len_in, base_len;
   logic [31:0]   hash_ff, hash_in, base_hash;
   logic [7:0]    v;
   logic          do_wr;

   always_comb begin
      base_len = ctl.restart ? '0 : len_ff;
      base_hash = ctl.restart ? '0 : hash_ff;
      v = (base_len == '0) ? to_lower(ch) : ch;
      do_wr = ctl.append && (base_len < LW'(WORD_MAX));
      len_after = do_wr ? base_len + LW'(1) : base_len;
      hash_after = do_wr ? sdbm_step(base_hash, v) : base_hash;
      len_in = ctl.clear ? '0 : len_after;
      hash_in = ctl.clear ? '0 : hash_after;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         hash_ff <= '0;
      end else begin
         len_ff <= len_in;
         hash_ff <= hash_in;
      end
      if (do_wr) begin
         char_ff[base_len[KW-1:0]] <= v;
      end
      if (do_wr && base_len == '0) begin
         first_raw_ff <= ch;
      end
   end

   assign rd_data = char_ff[rd_idx];
   assign abbrev = (len_ff == LW'(2)) &&
      ((first_raw_ff == CH_UP_M && (char_ff[1] == CH_LO_R || char_ff[1] == CH_LO_S)) ||
       (first_raw_ff == CH_UP_D && char_ff[1] == CH_LO_R));

endmodule

// ----- sim/tb_word_sentence_index_hash_unit.sv -----
`timescale 1ns / 1ps

module tb_word_sentence_index_hash_unit;
   import wsih_pkg::*;

   localparam int SLOTS = 1024;
   localparam int WMAX = 29;
   localparam int OCC_MAX = 16;
   localparam int SENT_TOP = 1023;
   localparam int IDLE_LIMIT = 200000;
   localparam int SWEEP_WAIT = 1500;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   typedef struct packed {
      logic [2:0] status;
      logic [9:0] slot;
      logic [9:0] sentence;
      logic       last;
   } index_result_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_func;
   logic [7:0] req_char_code;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_status;
   logic [9:0] rsp_slot_index;
   logic [9:0] rsp_sentence;
   logic       rsp_last_result;
   logic       csr_write_enable;
   logic [3:0] csr_write_data;

   index_result_type index_results_due[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  no_gaps = 0;

   // shadow of the index state
   logic [3:0]  order_reg;
   bit          w_active;
   logic [7:0]  w_buf [WMAX];
   int          w_len;
   logic [31:0] w_hash;
   int          sent_cnt;
   logic [7:0]  q_buf [WMAX];
   int          q_len;
   logic [31:0] q_hash;
   bit          tbl_used [SLOTS];
   logic [7:0]  tbl_word [SLOTS][WMAX];
   int          tbl_len [SLOTS];
   int          tbl_cnt [SLOTS];
   int          tbl_sent [SLOTS][OCC_MAX];
   logic [7:0]  key_buf [WMAX];

   word_sentence_index_hash_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_char_code(req_char_code),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_slot_index(rsp_slot_index),
      .rsp_sentence(rsp_sentence),
      .rsp_last_result(rsp_last_result),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] lower_first(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
   endfunction

   function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
      return {24'd0, c} + (h << 6) + (h << 16) - h;
   endfunction

   // 0 empty slot, 1 match, 2 full
   function automatic int find_slot(input int len, input logic [31:0] h, output int slot);
      int ord;
      int mask;
      int first;
      int j;
      bit same;
      ord = (order_reg < 5) ? 5 : (order_reg > 10) ? 10 : order_reg;
      mask = (1 << ord) - 1;
      first = h & mask;
      j = first;
      do begin
         if (!tbl_used[j]) begin
            slot = j;
            return 0;
         end
         if (tbl_len[j] == len) begin
            same = 1;
            for (int k = 0; k < len; k++)
               if (tbl_word[j][k] != key_buf[k]) same = 0;
            if (same) begin
               slot = j;
               return 1;
            end
         end
         j = (j + 1) & mask;
      end while (j != first);
      slot = first;
      return 2;
   endfunction

   function automatic void expect_result(input logic [2:0] st, input int slot, input int snt,
                                         input bit last);
      index_result_type r;
      r.status = st;
      r.slot = slot[9:0];
      r.sentence = snt[9:0];
      r.last = last;
      index_results_due.push_back(r);
   endfunction

   function automatic void store_word();
      int len;
      int slot;
      int kind;
      len = (w_len > WMAX) ? WMAX : w_len;
      for (int k = 0; k < len; k++) key_buf[k] = w_buf[k];
      if (len > 0) key_buf[0] = lower_first(key_buf[0]);
      kind = find_slot(len, w_hash, slot);
      if (kind == 0) begin
         tbl_used[slot] = 1;
         for (int k = 0; k < len; k++) tbl_word[slot][k] = key_buf[k];
         tbl_len[slot] = len;
         tbl_cnt[slot] = 1;
         tbl_sent[slot][0] = sent_cnt;
         expect_result(STAT_NEW, slot, sent_cnt, 1);
      end else if (kind == 1) begin
         if (tbl_cnt[slot] < OCC_MAX) begin
            tbl_sent[slot][tbl_cnt[slot]] = sent_cnt;
            tbl_cnt[slot]++;
            expect_result(STAT_ADDED, slot, sent_cnt, 1);
         end else begin
            expect_result(STAT_OCC_FULL, slot, sent_cnt, 1);
         end
      end else begin
         expect_result(STAT_FULL, slot, sent_cnt, 1);
      end
   endfunction

   function automatic void grow_word(input logic [7:0] c);
      if (w_len < WMAX) begin
         w_hash = hash_step(w_hash, (w_len == 0) ? lower_first(c) : c);
         w_buf[w_len] = c;
         w_len++;
      end
   endfunction

   function automatic void bump_sentence();
      if (sent_cnt < SENT_TOP) sent_cnt++;
   endfunction

   function automatic void predict_index(input logic [1:0] fn, input logic [7:0] c,
                                         input bit last);
      bit term;
      bit skip;
      bit abbrev;
      int slot;
      int kind;
      logic [7:0] v;
      if (fn == FUNC_PARA) begin
         term = (c == CH_EXCL || c == CH_DOT || c == CH_QUEST);
         skip = (c == CH_SPACE || c == CH_COMMA || c == CH_NL || c == CH_LPAR ||
                 c == CH_RPAR || c == CH_DQUOTE || c == CH_SQUOTE);
         if (!w_active) begin
            if (term) bump_sentence();
            else if (!skip) begin
               w_active = 1;
               w_len = 0;
               w_hash = 0;
               grow_word(c);
            end
         end else if (term) begin
            abbrev = (w_len == 2) &&
               ((w_buf[0] == CH_UP_M && (w_buf[1] == CH_LO_R || w_buf[1] == CH_LO_S)) ||
                (w_buf[0] == CH_UP_D && w_buf[1] == CH_LO_R));
            if (abbrev) begin
               grow_word(c);
               store_word();
            end else begin
               store_word();
               bump_sentence();
            end
            w_active = 0;
         end else if (skip) begin
            store_word();
            w_active = 0;
         end else begin
            grow_word(c);
         end
         if (last) begin
            w_active = 0;
            w_len = 0;
            w_hash = 0;
            sent_cnt = 0;
         end
      end else if (fn == FUNC_QUERY) begin
         if (q_len < WMAX) begin
            v = (q_len == 0) ? lower_first(c) : c;
            q_hash = hash_step(q_hash, v);
            q_buf[q_len] = v;
            q_len++;
         end
         if (last) begin
            for (int k = 0; k < q_len; k++) key_buf[k] = q_buf[k];
            kind = find_slot(q_len, q_hash, slot);
            if (kind == 1) begin
               for (int i = 0; i < tbl_cnt[slot]; i++)
                  expect_result(STAT_MATCH, slot, tbl_sent[slot][i], i + 1 == tbl_cnt[slot]);
            end else begin
               expect_result(STAT_NOT_FOUND, slot, 0, 1);
            end
            q_len = 0;
            q_hash = 0;
         end
      end else if (fn == FUNC_CLEAR) begin
         for (int k = 0; k < SLOTS; k++) tbl_used[k] = 0;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic send_byte(input logic [1:0] fn, input logic [7:0] c, input bit last);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= fn;
      req_char_code <= c;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      predict_index(fn, c, last);
   endtask

   task automatic send_text(input logic [1:0] fn, input string s, input bit last_at_end);
      for (int i = 0; i < s.len(); i++)
         send_byte(fn, s[i], last_at_end && (i == s.len() - 1));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (index_results_due.size() != 0) @(posedge clock);
      repeat (SWEEP_WAIT) @(posedge clock);
   endtask

   task automatic write_order(input logic [3:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      order_reg = value;
   endtask

   task automatic test_basic_text();
      send_text(FUNC_PARA, "Hi, all! Mr. Dr? Ms! (Q) \"x\" 'y'\n . hi ", 0);
      send_text(FUNC_PARA, "Abcdefghijklmnopqrstuvwxyz01234 ", 0);
      send_byte(FUNC_PARA, 8'h7a, 0);
      send_byte(FUNC_PARA, 8'h00, 0);
      send_byte(FUNC_PARA, 8'hff, 0);
      send_text(FUNC_PARA, " tail", 1);
   endtask

   task automatic test_queries();
      send_text(FUNC_QUERY, "hi", 1);
      send_text(FUNC_QUERY, "Mr.", 1);
      send_text(FUNC_QUERY, "zzz", 1);
      send_text(FUNC_QUERY, "abcdefghijklmnopqrstuvwxyz01234", 1);
      send_text(FUNC_QUERY, "tail", 1);
      send_byte(FUNC_NONE, 8'h41, 1);
      send_byte(FUNC_CLEAR, 8'h00, 0);
      send_text(FUNC_QUERY, "hi", 1);
   endtask

   task automatic test_occurrence_overflow();
      for (int i = 0; i < 17; i++) send_text(FUNC_PARA, "a!", 0);
      send_byte(FUNC_PARA, CH_SPACE, 1);
      send_text(FUNC_QUERY, "A", 1);
   endtask

   task automatic test_table_full();
      write_order(4'd0);
      send_byte(FUNC_CLEAR, 8'h00, 0);
      for (int i = 0; i < 33; i++) begin
         send_byte(FUNC_PARA, 8'(8'h61 + i), 0);
         send_byte(FUNC_PARA, CH_SPACE, i == 32);
      end
      send_byte(FUNC_QUERY, 8'h30, 1);
      send_byte(FUNC_CLEAR, 8'h00, 0);
   endtask

   task automatic test_random_text(input int n_items);
      string vocab [12] = '{"Mr", "Dr", "Ms", "apple", "Apple", "tree", "a", "go",
                            "river", "Stone", "x9", "longwordlongwordlongwordlongword"};
      string seps = " ,\n()\"'!.?";
      string wd;
      int    count;
      int    pick;
      count = 0;
      no_gaps = ($urandom_range(0, 3) == 0);
      while (count < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            wd = vocab[$urandom_range(0, 11)];
            if ($urandom_range(0, 1) == 1 && wd[0] >= "a" && wd[0] <= "z")
               wd[0] = wd[0] - 8'h20;
            send_text(FUNC_PARA, wd, 0);
            send_byte(FUNC_PARA, seps[$urandom_range(0, seps.len() - 1)],
                      $urandom_range(0, 15) == 0);
            count += wd.len() + 1;
         end else if (pick < 75) begin
            if ($urandom_range(0, 2) != 0) begin
               send_text(FUNC_QUERY, vocab[$urandom_range(0, 11)], 1);
               count += 3;
            end else begin
               for (int k = $urandom_range(1, 4); k > 0; k--) begin
                  send_byte(FUNC_QUERY, 8'($urandom_range(0, 255)), k == 1);
                  count++;
               end
            end
         end else if (pick < 95) begin
            send_byte(FUNC_PARA, 8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            count++;
         end else if (pick < 97) begin
            send_byte(FUNC_CLEAR, 8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1);
            count++;
         end else begin
            send_byte(FUNC_NONE, 8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1);
         end
         if ($urandom_range(0, 30) == 0) no_gaps = !no_gaps;
      end
      no_gaps = 0;
   endtask

   // result side: random stall per transfer, then compare with the oldest prediction
   initial begin
      int stall;
      index_result_type want;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (index_results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d slot %0d",
                                      rsp_status, rsp_slot_index));
         end else begin
            want = index_results_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d want %0d", rsp_status, want.status));
            if (rsp_slot_index !== want.slot)
               report_mismatch($sformatf("slot %0d want %0d", rsp_slot_index, want.slot));
            if (rsp_sentence !== want.sentence)
               report_mismatch($sformatf("sentence %0d want %0d", rsp_sentence,
                                         want.sentence));
            if (rsp_last_result !== want.last)
               report_mismatch($sformatf("last %0d want %0d", rsp_last_result, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_PARA;
      req_char_code <= 8'h00;
      req_last_byte <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data <= ORDER_RESET;
      order_reg = ORDER_RESET;
      w_active = 0;
      w_len = 0;
      w_hash = 0;
      sent_cnt = 0;
      q_len = 0;
      q_hash = 0;
      for (int k = 0; k < SLOTS; k++) tbl_used[k] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_basic_text();
      test_queries();
      test_occurrence_overflow();
      test_table_full();
      write_order(4'd15);
      test_random_text(14);
      drain();
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/wsih_pkg.sv
rtl/wsih_word_acc.sv
rtl/word_sentence_index_hash_unit.sv
sim/tb_word_sentence_index_hash_unit.sv
